// ===== src/first_fit_block_allocator_macros.svh =====
// assertion macros shared by the allocator checker
// no dependencies; included by the checker file only
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffba check failed");

// next-cycle implication, skipped while reset is high
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffba check failed");

`endif

// ===== src/ffba_pkg.sv =====
// shared types and constants for the first-fit block allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ffba_pkg;

  // table geometry and block layout
  localparam int MAX_BLOCKS    = 64;
  localparam int HEADER_BYTES  = 8;
  localparam int TRAILER_BYTES = 4;
  localparam int IDX_W         = $clog2(MAX_BLOCKS);
  localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // one request beat
  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  // one result beat
  typedef struct packed {
    logic [31:0] granted_address;
    status_t     status;
    logic [31:0] used_bytes;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic take_hit;
    logic calc_end;
    logic append;
    logic fin_zero;
    logic fin_missing;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_zero;
    logic is_free;
    logic at_end;
    logic hit;
  } dp_stat_t;

endpackage

// ===== src/ffba_datapath.sv =====
// allocator datapath: config registers, block table, walk pointer and accounting
// depends on ffba_pkg; driven by ffba_ctrl commands
`timescale 1ns / 1ps

module ffba_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ffba_pkg::req_t                  req,
  input  ffba_pkg::dp_cmd_t               cmd,
  output ffba_pkg::dp_stat_t              stat,
  output ffba_pkg::rsp_t                  rsp
);
  import ffba_pkg::*;

  logic [31:0]      heap_base;
  logic [31:0]      heap_limit;
  opcode_t          op;
  logic [31:0]      req_size;
  logic [31:0]      rel_addr;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [31:0]      pos;
  logic [33:0]      end_sum;
  logic [31:0]      size_q;
  logic [31:0]      size_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] block_busy;
  logic [CNT_W-1:0] block_count;
  logic [31:0]      bump_offset;
  logic [31:0]      used_count;
  logic [31:0]      used_next;
  logic             fits;
  rsp_t             rsp_q;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_LIMIT: heap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk index, read address runs one step ahead of the registered size
  always_comb begin
    idx_next = idx;
    if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.advance) begin
      idx_next = idx + CNT_W'(1);
    end
  end

  // status back to the controller
  assign fits = (block_count != CNT_W'(MAX_BLOCKS)) && (end_sum < {2'b00, heap_limit});
  always_comb begin
    stat.new_zero = (req.opcode == OP_ALLOC) && (req.request_size == '0);
    stat.is_free  = (op == OP_FREE);
    stat.at_end   = (idx == block_count);
    if (op == OP_ALLOC) begin
      stat.hit = !block_busy[idx[IDX_W-1:0]] && (size_q >= req_size);
    end else begin
      stat.hit = (pos + 32'(HEADER_BYTES)) == rel_addr;
    end
  end

  // used-byte accounting for the finishing step
  always_comb begin
    used_next = used_count;
    if (cmd.take_hit) begin
      if (op == OP_ALLOC) begin
        used_next = used_count + req_size + 32'(HEADER_BYTES);
      end else begin
        used_next = used_count - (size_q + 32'(HEADER_BYTES));
      end
    end else if (cmd.append && fits) begin
      used_next = used_count + req_size + 32'(HEADER_BYTES + TRAILER_BYTES);
    end
  end

  // block size table, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.append && fits) begin
      size_mem[block_count[IDX_W-1:0]] <= req_size;
    end
    size_q <= size_mem[idx_next[IDX_W-1:0]];
  end

  // table control state and accounting
  always_ff @(posedge clk) begin
    if (rst) begin
      block_busy  <= '0;
      block_count <= '0;
      bump_offset <= '0;
      used_count  <= '0;
      idx         <= '0;
    end else begin
      idx        <= idx_next;
      used_count <= used_next;
      if (cmd.take_hit) begin
        block_busy[idx[IDX_W-1:0]] <= (op == OP_ALLOC);
      end
      if (cmd.append && fits) begin
        block_busy[block_count[IDX_W-1:0]] <= 1'b1;
        block_count <= block_count + CNT_W'(1);
        bump_offset <= bump_offset + req_size + 32'(HEADER_BYTES + TRAILER_BYTES);
      end
    end
  end

  // request latch, walk address and bump end check
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req.opcode;
      req_size <= req.request_size;
      rel_addr <= req.release_address;
      pos      <= heap_base;
    end else if (cmd.advance) begin
      pos <= pos + size_q + 32'(HEADER_BYTES + TRAILER_BYTES);
    end
    if (cmd.calc_end) begin
      end_sum <= {2'b00, heap_base} + {2'b00, bump_offset} + {2'b00, req_size}
                 + 34'(HEADER_BYTES);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin_zero) begin
      rsp_q.granted_address <= '0;
      rsp_q.status          <= ST_ZERO_SIZE;
      rsp_q.used_bytes      <= used_next;
    end else if (cmd.take_hit) begin
      rsp_q.granted_address <= (op == OP_ALLOC) ? pos + 32'(HEADER_BYTES) : '0;
      rsp_q.status          <= ST_OK;
      rsp_q.used_bytes      <= used_next;
    end else if (cmd.append) begin
      rsp_q.granted_address <= fits ? heap_base + bump_offset + 32'(HEADER_BYTES) : '0;
      rsp_q.status          <= fits ? ST_OK : ST_NO_SPACE;
      rsp_q.used_bytes      <= used_next;
    end else if (cmd.fin_missing) begin
      rsp_q.granted_address <= '0;
      rsp_q.status          <= ST_NOT_FOUND;
      rsp_q.used_bytes      <= used_next;
    end
  end

  assign rsp = rsp_q;

endmodule

// ===== src/ffba_ctrl.sv =====
// allocator controller: sequences accept, table walk, append and result strobe
// depends on ffba_pkg; drives ffba_datapath
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import ffba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPEND
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  // next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.new_zero) begin
            cmd.fin_zero = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.at_end) begin
          if (stat.is_free) begin
            cmd.fin_missing = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.calc_end = 1'b1;
            state_next   = S_APPEND;
          end
        end else if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign finish = cmd.fin_zero | cmd.take_hit | cmd.append | cmd.fin_missing;
  assign busy   = (state != S_IDLE);

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit heap allocator over an ordered table of up to 64 blocks. A request beat is
// taken when start is high and busy is low; its result appears on rsp for exactly one
// cycle with done high and must be captured then, since the block cannot be held off.
// A zero-size allocate answers on the cycle after acceptance. Any other request walks
// the block table one entry per cycle from the first block, limited by the single read
// port of the block size memory: a hit answers once its entry is checked, a free that
// matches nothing answers once the walk reaches block_count, and an allocate that falls
// through computes the bump end and appends in S_APPEND before it answers. For a walk,
// busy is high from the cycle after acceptance until the result cycle, when a new request
// may be taken; a zero-size allocate never raises busy. The user must write heap_base and
// heap_limit only while busy is low and no result is pending. The block itself does not
// enforce this. Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
`timescale 1ns / 1ps

module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ffba_pkg::req_t                  req,
  output logic                            done,
  output ffba_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // table and arithmetic
  ffba_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

// ===== src/ffba_checker.sv =====
// port-level checks for the allocator, bound to the top level
// depends on ffba_pkg and first_fit_block_allocator_macros.svh
`timescale 1ns / 1ps
`include "first_fit_block_allocator_macros.svh"

module ffba_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input ffba_pkg::req_t req,
  input logic           done,
  input ffba_pkg::rsp_t rsp
);
  import ffba_pkg::*;

  logic take;
  logic zero_req;
  logic zero_rsp;

  assign take     = start && !busy;
  assign zero_req = (req.opcode == OP_ALLOC) && (req.request_size == '0);
  assign zero_rsp = (rsp.status == ST_ZERO_SIZE) && (rsp.granted_address == '0);

  // zero-size allocate answers without a walk, with a null address
  `FFBA_ASSERT_NEXT(a_zero_fast, clk, rst, take && zero_req, done && zero_rsp)

  // any other beat occupies the block for a walk
  `FFBA_ASSERT_NEXT(a_walk_busy, clk, rst, take && !zero_req, busy && !done)

  // failed requests never hand out an address
  `FFBA_ASSERT_NOW(a_fail_null, clk, rst, done && (rsp.status != ST_OK), rsp.granted_address == '0)

  // the end of a walk always delivers its result
  `FFBA_ASSERT_NOW(a_end_done, clk, rst, $fell(busy), done)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the first-fit block allocator
// depends on ffba_pkg and first_fit_block_allocator; drives requests and config writes
`timescale 1ns / 1ps

module testbench;
  import ffba_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;

  // heap layouts used by the random phases
  typedef enum {
    LAYOUT_TIGHT,
    LAYOUT_EMPTY_RANGE,
    LAYOUT_TOP,
    LAYOUT_OPEN
  } heap_layout_t;

  // mirror of the block table plus the queue of predicted result beats
  class heap_tracker;
    logic [31:0] base_addr;
    logic [31:0] limit_addr;
    logic [31:0] sizes [MAX_BLOCKS];
    bit          busy_mark [MAX_BLOCKS];
    int unsigned n_blocks;
    logic [31:0] bump;
    logic [31:0] used;
    rsp_t        pending_rsp [$];
    int unsigned mismatches;

    function new();
      base_addr  = '0;
      limit_addr = '1;
      n_blocks   = 0;
      bump       = '0;
      used       = '0;
      mismatches = 0;
      foreach (busy_mark[i]) busy_mark[i] = 1'b0;
      foreach (sizes[i]) sizes[i] = '0;
    endfunction

    function void set_heap(logic [31:0] b, logic [31:0] l);
      base_addr  = b;
      limit_addr = l;
    endfunction

    // payload address of table entry k under the current base
    function logic [31:0] payload_of(int unsigned k);
      logic [31:0] pos;
      pos = base_addr;
      for (int unsigned i = 0; i < k; i++)
        pos = pos + sizes[i] + 32'(HEADER_BYTES) + 32'(TRAILER_BYTES);
      return pos + 32'(HEADER_BYTES);
    endfunction

    // work out the result beat of one accepted request and update the mirror
    function void take_request(req_t r);
      rsp_t        want;
      logic [31:0] pos;
      logic [31:0] pay;
      logic [63:0] stop;
      bit          hit;
      int unsigned i;
      want        = '0;
      want.status = ST_OK;
      pos         = base_addr;
      hit         = 1'b0;
      if (r.opcode == OP_ALLOC) begin
        if (r.request_size == '0) begin
          want.status = ST_ZERO_SIZE;
        end else begin
          // first fit over the table, no split
          for (i = 0; i < n_blocks && !hit; i++) begin
            if (!busy_mark[i] && sizes[i] >= r.request_size) begin
              busy_mark[i] = 1'b1;
              used = used + r.request_size + 32'(HEADER_BYTES);
              want.granted_address = pos + 32'(HEADER_BYTES);
              hit = 1'b1;
            end else begin
              pos = pos + sizes[i] + 32'(HEADER_BYTES) + 32'(TRAILER_BYTES);
            end
          end
          // append at the bump end, bound checked without wrap
          if (!hit) begin
            stop = {32'b0, base_addr} + {32'b0, bump} + {32'b0, r.request_size}
                 + 64'(HEADER_BYTES);
            if (n_blocks >= MAX_BLOCKS || stop >= {32'b0, limit_addr}) begin
              want.status = ST_NO_SPACE;
            end else begin
              want.granted_address = base_addr + bump + 32'(HEADER_BYTES);
              sizes[n_blocks]     = r.request_size;
              busy_mark[n_blocks] = 1'b1;
              n_blocks++;
              bump = bump + r.request_size + 32'(HEADER_BYTES) + 32'(TRAILER_BYTES);
              used = used + r.request_size + 32'(TRAILER_BYTES) + 32'(HEADER_BYTES);
            end
          end
        end
      end else begin
        // free walks to the matching payload address
        for (i = 0; i < n_blocks && !hit; i++) begin
          pay = pos + 32'(HEADER_BYTES);
          if (pay == r.release_address) begin
            busy_mark[i] = 1'b0;
            used = used - (sizes[i] + 32'(HEADER_BYTES));
            hit = 1'b1;
          end else begin
            pos = pos + sizes[i] + 32'(HEADER_BYTES) + 32'(TRAILER_BYTES);
          end
        end
        if (!hit) want.status = ST_NOT_FOUND;
      end
      want.used_bytes = used;
      pending_rsp.push_back(want);
    endfunction

    // compare one result beat against the oldest prediction
    function void match_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: addr %h status %0d used %h",
                   got.granted_address, got.status, got.used_bytes);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.granted_address !== want.granted_address || got.status !== want.status ||
          got.used_bytes !== want.used_bytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: addr %h/%h status %0d/%0d used %h/%h (got/exp)",
                   got.granted_address, want.granted_address, got.status, want.status,
                   got.used_bytes, want.used_bytes);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req = '0;
  logic                  done;
  rsp_t                  rsp;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heap_tracker book;
  int unsigned quiet_cycles = 0;

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // result capture and idle-cycle count
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) book.match_result(rsp);
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // send one request beat after a random gap, return once it is taken
  task automatic issue(opcode_t op, logic [31:0] size, logic [31:0] addr);
    req_t r;
    int   gap;
    r.opcode          = op;
    r.request_size    = size;
    r.release_address = addr;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    book.take_request(r);
  endtask

  // hold off until every predicted beat has come back
  task automatic drain();
    start <= 1'b0;
    while (book.pending_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // write both heap registers on back-to-back cycles
  task automatic program_heap(logic [31:0] b, logic [31:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAP_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_HEAP_LIMIT;
    cfg_data  <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_heap(b, l);
  endtask

  // mostly allocs and frees of live blocks, some stray addresses and huge sizes
  task automatic random_beat();
    int          pick;
    int unsigned k;
    logic [31:0] size;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    size = $urandom;
    addr = $urandom;
    k = (book.n_blocks > 0) ? $urandom_range(0, book.n_blocks - 1) : 0;
    if (pick < 45) begin
      if (book.n_blocks > 0 && $urandom_range(0, 1) == 1)
        size = book.sizes[k] - $urandom_range(0, 2);
      else
        size = $urandom_range(1, 48);
      if (size == '0) size = 32'd1;
      issue(OP_ALLOC, size, addr);
    end else if (pick < 80) begin
      if (book.n_blocks > 0) addr = book.payload_of(k);
      issue(OP_FREE, size, addr);
    end else if (pick < 88) begin
      if (book.n_blocks > 0 && $urandom_range(0, 1) == 1)
        addr = book.payload_of(k) + $urandom_range(1, 3);
      issue(OP_FREE, size, addr);
    end else if (pick < 95) begin
      issue(OP_ALLOC, size, addr);
    end else begin
      issue(OP_ALLOC, '0, addr);
    end
  endtask

  // idle the block, then move the heap window for the next phase
  task automatic start_phase(heap_layout_t layout);
    logic [31:0] b;
    logic [31:0] l;
    logic [32:0] head;
    drain();
    if (book.bump > 32'hFFFF_DFFF) b = '0;
    else b = $urandom_range(0, 32'hFFFF_DFFF - book.bump);
    case (layout)
      LAYOUT_EMPTY_RANGE: begin
        b = '0;
        l = '0;
      end
      LAYOUT_TOP: begin
        b = '1;
        l = '1;
      end
      LAYOUT_OPEN: begin
        l = '1;
      end
      default: begin
        head = {1'b0, b} + {1'b0, book.bump} + 33'($urandom_range(200, 800));
        l = head[32] ? '1 : head[31:0];
      end
    endcase
    program_heap(b, l);
  endtask

  heap_layout_t plan [8] = '{LAYOUT_TIGHT, LAYOUT_EMPTY_RANGE, LAYOUT_TIGHT, LAYOUT_TIGHT,
                             LAYOUT_TOP, LAYOUT_TIGHT, LAYOUT_TIGHT, LAYOUT_OPEN};

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero size, empty table, oversize, append, reuse, double free
    issue(OP_ALLOC, '0, 32'h0000_0008);
    issue(OP_FREE, 32'h0000_0001, 32'h0000_0008);
    issue(OP_ALLOC, 32'hFFFF_FFFF, '0);
    issue(OP_ALLOC, 32'd1, '0);
    issue(OP_ALLOC, 32'd16, '0);
    issue(OP_FREE, '0, book.payload_of(0));
    issue(OP_FREE, '0, book.payload_of(0));
    issue(OP_FREE, '0, book.payload_of(1));
    // used count wraps below zero
    issue(OP_FREE, '0, book.payload_of(1));
    issue(OP_ALLOC, 32'd1, '0);
    issue(OP_ALLOC, 32'd10, '0);
    issue(OP_ALLOC, 32'd2, '0);
    issue(OP_FREE, '0, book.payload_of(1) + 32'd1);
    issue(OP_FREE, '0, 32'hFFFF_FFFF);
    // huge block, then reuse by a smaller huge request
    issue(OP_ALLOC, 32'hF000_0000, 32'hFFFF_FFFF);
    issue(OP_FREE, '0, book.payload_of(3));
    issue(OP_ALLOC, 32'h8000_0000, '0);

    // limit boundary: end equal to limit is refused, one below is taken
    drain();
    program_heap(book.base_addr, book.base_addr + book.bump + 32'd13);
    issue(OP_ALLOC, 32'd5, '0);
    issue(OP_ALLOC, 32'd4, '0);
    issue(OP_FREE, 32'hFFFF_FFFF, book.payload_of(0));

    // addresses follow a moved base
    drain();
    program_heap(32'h0000_1000, '1);
    issue(OP_FREE, '0, book.payload_of(2));
    issue(OP_ALLOC, 32'd2, '0);

    // random phases over several heap windows
    foreach (plan[p]) begin
      start_phase(plan[p]);
      if (plan[p] == LAYOUT_OPEN) begin
        // fill the table so later appends hit the full-table case
        for (int n = 0; n < 200 && book.n_blocks < MAX_BLOCKS; n++)
          issue(OP_ALLOC, $urandom_range(1, 64), '0);
        repeat (100) random_beat();
      end else begin
        repeat (130) random_beat();
      end
    end

    // wait out the last beats and the walk latency
    start <= 1'b0;
    while (book.pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending_rsp.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
